>>> design/template_escape_unescaper_core_assert.svh
// assertion macros used by the unescaper core design file
`ifndef TEMPLATE_ESCAPE_UNESCAPER_CORE_ASSERT_SVH
`define TEMPLATE_ESCAPE_UNESCAPER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TEU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TEU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/teu_pkg.sv
// constants, types and helper functions of the template escape unescaper
package teu_pkg;

  // scanner state codes
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StDol    = 4'd1;
  localparam logic [3:0] StDolBs  = 4'd2;
  localparam logic [3:0] StBs     = 4'd3;
  localparam logic [3:0] StLt     = 4'd4;
  localparam logic [3:0] StLtBs   = 4'd5;
  localparam logic [3:0] StHash   = 4'd6;
  localparam logic [3:0] StHashBs = 4'd7;
  localparam logic [3:0] StPct    = 4'd8;
  localparam logic [3:0] StPctBs  = 4'd9;
  localparam logic [3:0] StQm     = 4'd10;
  localparam logic [3:0] StQmBs   = 4'd11;

  // characters that take part in escape sequences
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChPct    = 8'h25;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChQm     = 8'h3F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLcurly = 8'h7B;
  localparam logic [7:0] ChRcurly = 8'h7D;

  // up to three result bytes of one input byte, first in slot 0
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
  } emit_t;

  // append one byte to the result list
  function automatic emit_t put(emit_t e, logic [7:0] b);
    emit_t r;
    r = e;
    if (e.cnt != 2'd3) begin
      r.bytes[e.cnt] = b;
      r.cnt = e.cnt + 2'd1;
    end
    return r;
  endfunction

  // append the pending bytes of a candidate
  function automatic emit_t flush(emit_t e, logic [7:0] p0, logic [7:0] p1, logic [1:0] n);
    emit_t r;
    r = e;
    if (n != 2'd0) begin
      r = put(r, p0);
    end
    if (n == 2'd2) begin
      r = put(r, p1);
    end
    return r;
  endfunction

endpackage

>>> design/template_escape_unescaper_core.sv
// template escape unescaper: byte scanner with a three-entry result buffer
//
// Bytes of an escaped string enter on s_axis (tdata = data_byte, tlast = string_end).
// Unescaped bytes leave on m_axis (tdata = out_byte, tlast = last result of the
// input byte, tuser = final byte of the string). One input byte gives zero to
// three result bytes. The percent escape is enabled by the one-bit register on
// the cfg channel, written by the user while the stream is idle; the block
// does not enforce this. The first result of a byte is shown the cycle after the
// byte is taken. Throughput: one byte per cycle while each byte gives at most one
// result and the receiver is ready; a byte with more results holds the input
// while the single output port drains the buffer one byte a cycle, as the receiver
// takes them. Bytes that only extend a candidate give no result and never stall.
// Reset clears the scanner to idle, drops all pending and buffered bytes and
// disables the percent escape.
// A stalled receiver holds the buffered results; a new byte is taken as soon as
// the last buffered result leaves, in the same cycle.
module template_escape_unescaper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_wdata_i,     // percent_escape_enable
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] data_byte
  input  logic       s_axis_tlast,    // string_end
  // result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [7:0] out_byte
  output logic       m_axis_tlast,    // run_last
  output logic       m_axis_tuser     // [0] string_done
);

  logic            pct_en_q;
  logic [3:0]      state_q, state_d;
  logic [1:0]      pend_cnt_q, pend_cnt_d;
  logic [7:0]      pend0_q, pend0_d, pend1_q, pend1_d;
  logic [2:0][7:0] obuf_q;
  logic [1:0]      out_cnt_q;
  logic            out_end_q;
  logic            in_req, out_req;
  logic [1:0]      pc;
  logic [7:0]      ch;
  teu_pkg::emit_t  em;

  assign in_req  = s_axis_tvalid & s_axis_tready;
  assign out_req = m_axis_tvalid & m_axis_tready;
  assign ch      = s_axis_tdata;
  assign pc      = (pend_cnt_q == 2'd3) ? 2'd2 : pend_cnt_q;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      pct_en_q <= cfg_wdata_i;
    end
  end

  // scanner step for the offered byte
  always_comb begin
    em         = '0;
    state_d    = state_q;
    pend0_d    = pend0_q;
    pend1_d    = pend1_q;
    pend_cnt_d = pc;
    unique case (ch)
      teu_pkg::ChDollar, teu_pkg::ChHash, teu_pkg::ChPct, teu_pkg::ChLt: begin
        em         = teu_pkg::flush(em, pend0_q, pend1_q, pc);
        pend0_d    = ch;
        pend_cnt_d = 2'd1;
        unique case (ch)
          teu_pkg::ChDollar: state_d = teu_pkg::StDol;
          teu_pkg::ChHash:   state_d = teu_pkg::StHash;
          teu_pkg::ChPct:    state_d = teu_pkg::StPct;
          default:           state_d = teu_pkg::StLt;
        endcase
      end
      teu_pkg::ChBslash: begin
        if ((state_q == teu_pkg::StDol || state_q == teu_pkg::StLt ||
             state_q == teu_pkg::StHash || state_q == teu_pkg::StPct ||
             state_q == teu_pkg::StQm) && pc == 2'd1) begin
          pend1_d    = ch;
          pend_cnt_d = 2'd2;
          state_d    = state_q + 4'd1;
        end else begin
          em         = teu_pkg::flush(em, pend0_q, pend1_q, pc);
          pend0_d    = ch;
          pend_cnt_d = 2'd1;
          state_d    = teu_pkg::StBs;
        end
      end
      teu_pkg::ChQm: begin
        if (state_q == teu_pkg::StLtBs) begin
          em         = teu_pkg::put(teu_pkg::put(em, teu_pkg::ChLt), teu_pkg::ChQm);
          pend_cnt_d = 2'd0;
          state_d    = teu_pkg::StIdle;
        end else begin
          em         = teu_pkg::flush(em, pend0_q, pend1_q, pc);
          pend0_d    = ch;
          pend_cnt_d = 2'd1;
          state_d    = teu_pkg::StQm;
        end
      end
      teu_pkg::ChGt: begin
        if (state_q == teu_pkg::StQmBs) begin
          em = teu_pkg::put(teu_pkg::put(em, teu_pkg::ChQm), teu_pkg::ChGt);
        end else begin
          em = teu_pkg::put(teu_pkg::flush(em, pend0_q, pend1_q, pc), ch);
        end
        pend_cnt_d = 2'd0;
        state_d    = teu_pkg::StIdle;
      end
      teu_pkg::ChLcurly: begin
        if (state_q == teu_pkg::StDolBs) begin
          em = teu_pkg::put(teu_pkg::put(em, teu_pkg::ChDollar), ch);
        end else if (state_q == teu_pkg::StHashBs) begin
          em = teu_pkg::put(teu_pkg::put(em, teu_pkg::ChHash), ch);
        end else if (state_q == teu_pkg::StPctBs && pct_en_q) begin
          em = teu_pkg::put(teu_pkg::put(em, teu_pkg::ChPct), ch);
        end else begin
          em = teu_pkg::put(teu_pkg::flush(em, pend0_q, pend1_q, pc), ch);
        end
        pend_cnt_d = 2'd0;
        state_d    = teu_pkg::StIdle;
      end
      teu_pkg::ChRcurly: begin
        if ((state_q == teu_pkg::StDolBs || state_q == teu_pkg::StLtBs ||
             state_q == teu_pkg::StHashBs || state_q == teu_pkg::StQmBs) &&
            pc != 2'd0) begin
          // backslash dropped, leading character kept
          em = teu_pkg::put(teu_pkg::put(em, pend0_q), ch);
        end else if (state_q == teu_pkg::StBs) begin
          em = teu_pkg::put(em, ch);
        end else begin
          em = teu_pkg::put(teu_pkg::flush(em, pend0_q, pend1_q, pc), ch);
        end
        pend_cnt_d = 2'd0;
        state_d    = teu_pkg::StIdle;
      end
      default: begin
        em         = teu_pkg::put(teu_pkg::flush(em, pend0_q, pend1_q, pc), ch);
        pend_cnt_d = 2'd0;
        state_d    = teu_pkg::StIdle;
      end
    endcase
    // end of string flushes what is still held
    if (s_axis_tlast) begin
      em         = teu_pkg::flush(em, pend0_d, pend1_d, pend_cnt_d);
      pend_cnt_d = 2'd0;
      state_d    = teu_pkg::StIdle;
    end
  end

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= teu_pkg::StIdle;
      pend_cnt_q <= 2'd0;
    end else if (in_req) begin
      state_q    <= state_d;
      pend_cnt_q <= pend_cnt_d;
    end
  end

  // pending candidate bytes
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      pend0_q <= pend0_d;
      pend1_q <= pend1_d;
    end
  end

  // take a byte once the buffer is empty or its last result leaves
  assign s_axis_tready = (out_cnt_q == 2'd0) || (out_cnt_q == 2'd1 && m_axis_tready);

  // result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= 2'd0;
    end else if (in_req) begin
      out_cnt_q <= em.cnt;
    end else if (out_req) begin
      out_cnt_q <= out_cnt_q - 2'd1;
    end
  end

  // result buffer data, head in slot 0
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      obuf_q    <= em.bytes;
      out_end_q <= s_axis_tlast;
    end else if (out_req) begin
      obuf_q[0] <= obuf_q[1];
      obuf_q[1] <= obuf_q[2];
    end
  end

  assign m_axis_tvalid = (out_cnt_q != 2'd0);
  assign m_axis_tdata  = obuf_q[0];
  assign m_axis_tlast  = (out_cnt_q == 2'd1);
  assign m_axis_tuser  = (out_cnt_q == 2'd1) && out_end_q;

`include "template_escape_unescaper_core_assert.svh"

  `TEU_ASSERT_NOW(a_idle_no_pending, state_q == teu_pkg::StIdle, pend_cnt_q == 2'd0, "pending bytes in idle state")
  `TEU_ASSERT_NEXT(a_end_gives_result, in_req && s_axis_tlast, m_axis_tvalid, "end of string without result")
  `TEU_ASSERT_NEXT(a_end_resets_scan, in_req && s_axis_tlast, state_q == teu_pkg::StIdle && pend_cnt_q == 2'd0, "scanner not idle after end of string")
  `TEU_ASSERT_NOW(a_no_take_while_full, out_cnt_q > 2'd1, !s_axis_tready, "byte taken over buffered results")

endmodule
